FILE: sv/kbrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbrf_pkg: shared types and constants for the keyboard report filter
// Widths, register indexes, reset values and the transfer types passed
// between the front end, the result queue and the back end.
// ----------------------------------------------------------------------------
package kbrf_pkg;

	localparam int WORD_W     = 32;
	localparam int KEY_W      = 8;
	localparam int KEYS_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MAX_OUT      = 3;
	localparam int RESULT_CAP   = 3;
	localparam int RESULT_LIMIT = (MAX_OUT < RESULT_CAP) ? MAX_OUT : RESULT_CAP;
	localparam int CNT_W        = $clog2(RESULT_CAP + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPEAT_WINDOW = 3'd0,
		REG_CONTROL_CODE  = 3'd1,
		REG_LEFT_SHIFT    = 3'd2,
		REG_RIGHT_SHIFT   = 3'd3,
		REG_SHIFT_MARKER  = 3'd4
	} cfg_idx_t;

	localparam word_t RST_REPEAT_WINDOW = 32'd30375000;
	localparam key_t  RST_CONTROL_CODE  = 8'd86;
	localparam key_t  RST_LEFT_SHIFT    = 8'd84;
	localparam key_t  RST_RIGHT_SHIFT   = 8'd85;
	localparam key_t  RST_SHIFT_MARKER  = 8'd1;

	localparam logic STATUS_KEY      = 1'b0;
	localparam logic STATUS_LINK_ERR = 1'b1;

	// results of one report, slot 0 goes out first
	typedef struct packed {
		cnt_t                       count;
		logic                       err;
		logic [RESULT_CAP-1:0][KEY_W-1:0] keys;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} bundle_xfer_t;

endpackage

FILE: sv/kbrf_report_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbrf_report_if: keyboard report input channel
// Valid/ready channel carrying one 64-bit report and its arrival tick.
// ----------------------------------------------------------------------------
interface kbrf_report_if;
	logic                valid;
	logic                ready;
	kbrf_pkg::word_t     report_high;
	kbrf_pkg::word_t     report_low;
	kbrf_pkg::word_t     now_tick;

	modport source (output valid, output report_high, output report_low, output now_tick,
		input ready);
	modport sink (input valid, input report_high, input report_low, input now_tick,
		output ready);
endinterface

FILE: sv/kbrf_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbrf_result_if: key event output channel
// Valid/ready channel carrying one key code, its status and a last flag.
// ----------------------------------------------------------------------------
interface kbrf_result_if;
	logic           valid;
	logic           ready;
	kbrf_pkg::key_t key_out;
	logic           status;
	logic           last;

	modport source (output valid, output key_out, output status, output last, input ready);
	modport sink (input valid, input key_out, input status, input last, output ready);
endinterface

FILE: sv/kbrf_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbrf_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface kbrf_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [kbrf_pkg::CFG_IDX_W-1:0]       index;
	logic [kbrf_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/keyboard_report_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_filter_top: keyboard report filter
// Checks keyboard link reports, drops repeats and emits key events.
// ----------------------------------------------------------------------------
// Path: an accepted report is written to the two-entry bundle queue, and its
// first result is then loaded into the output register. Throughput: one
// report per cycle while the queue has room; the output stage drains one
// result per cycle while result.ready is high, at most three per report.
// Reset: clears filter state and queue, loads register defaults; no sweep.
// ----------------------------------------------------------------------------
module keyboard_report_filter_top (
	input  logic           clk,
	input  logic           arst_n,
	kbrf_report_if.sink    report,
	kbrf_result_if.source  result,
	kbrf_cfg_if.sink       cfg
);
	import kbrf_pkg::*;

	bundle_xfer_t push;
	bundle_xfer_t head;
	logic         queue_full;
	logic         pop;

	kbrf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.report     (report),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push       (push)
	);

	kbrf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.head   (head),
		.pop    (pop)
	);

	kbrf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

FILE: sv/kbrf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbrf_front: report checker and key decoder
// Holds the configuration registers and filter state, checks each report,
// drops duplicates and turns the rest into a bundle of up to three results.
// ----------------------------------------------------------------------------
module kbrf_front (
	input  logic                   clk,
	input  logic                   arst_n,
	kbrf_report_if.sink            report,
	kbrf_cfg_if.sink               cfg,
	input  logic                   queue_full,
	output kbrf_pkg::bundle_xfer_t push
);
	import kbrf_pkg::*;

	word_t            win_q;
	key_t             ctrl_q;
	key_t             lshift_q;
	key_t             rshift_q;
	key_t             marker_q;

	logic [KEYS_W-1:0] prev_q;
	word_t            time_q;
	logic             pend_q;

	logic             accept;
	key_t             sum;
	logic             bad;
	logic [KEYS_W-1:0] keys;
	word_t            elapsed;
	logic             dup;
	key_t             b [RESULT_CAP];
	cnt_t             num;
	logic             pend_nxt;
	logic [RESULT_CAP-1:0][KEY_W-1:0] outk;

	function automatic logic was_held(input logic [KEYS_W-1:0] old, input key_t code);
		logic hit;
		hit = 1'b0;
		for (int j = 0; j < RESULT_CAP; j++) begin
			if (old[KEYS_W-1-KEY_W*j -: KEY_W] == code) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	assign report.ready = !queue_full;
	assign accept       = report.valid && report.ready;
	assign cfg.ready    = 1'b1;

	always_comb begin
		sum = report.report_high[31:24] ^ report.report_high[23:16] ^
			report.report_high[15:8] ^ report.report_high[7:0] ^
			report.report_low[31:24] ^ report.report_low[23:16] ^ report.report_low[15:8];
		bad = report.report_high[31] || report.report_high[29] || report.report_high[28] ||
			(report.report_low[7:0] != sum);
		keys    = report.report_low[31:8];
		elapsed = report.now_tick - time_q;
		dup     = (keys == prev_q) && (elapsed < win_q);

		for (int i = 0; i < RESULT_CAP; i++) begin
			b[i] = keys[KEYS_W-1-KEY_W*i -: KEY_W];
		end

		num      = '0;
		pend_nxt = pend_q;
		outk     = '0;

		// control keys go out first, even when already held
		for (int i = 0; i < RESULT_CAP; i++) begin
			if (b[i] == ctrl_q) begin
				b[i] = '0;
				if (num < cnt_t'(RESULT_LIMIT)) begin
					outk[num] = ctrl_q;
					num       = num + cnt_t'(1);
				end
			end
		end

		for (int i = 0; i < RESULT_CAP; i++) begin
			if (b[i] != '0) begin
				if (b[i] == lshift_q || b[i] == rshift_q) begin
					pend_nxt = 1'b1;
				end else if (!was_held(prev_q, b[i])) begin
					if (pend_nxt && num < cnt_t'(RESULT_LIMIT)) begin
						pend_nxt  = 1'b0;
						outk[num] = marker_q;
						num       = num + cnt_t'(1);
					end
					if (num < cnt_t'(RESULT_LIMIT)) begin
						outk[num] = b[i];
						num       = num + cnt_t'(1);
					end
				end
			end
		end

		push.valid = accept && (bad || (!dup && keys != '0 && num != '0));
		push.data.err = bad;
		if (bad) begin
			push.data.count = cnt_t'(1);
			push.data.keys  = '0;
		end else begin
			push.data.count = num;
			push.data.keys  = outk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			time_q <= '0;
			pend_q <= 1'b0;
		end else if (accept && !bad && !dup) begin
			prev_q <= keys;
			time_q <= report.now_tick;
			pend_q <= (keys == '0) ? 1'b0 : pend_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= RST_REPEAT_WINDOW;
			ctrl_q   <= RST_CONTROL_CODE;
			lshift_q <= RST_LEFT_SHIFT;
			rshift_q <= RST_RIGHT_SHIFT;
			marker_q <= RST_SHIFT_MARKER;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_REPEAT_WINDOW: win_q    <= cfg.data;
				REG_CONTROL_CODE:  ctrl_q   <= cfg.data[KEY_W-1:0];
				REG_LEFT_SHIFT:    lshift_q <= cfg.data[KEY_W-1:0];
				REG_RIGHT_SHIFT:   rshift_q <= cfg.data[KEY_W-1:0];
				REG_SHIFT_MARKER:  marker_q <= cfg.data[KEY_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/kbrf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbrf_queue: result bundle queue
// Short register FIFO of decoded bundles between the front and back ends.
// ----------------------------------------------------------------------------
module kbrf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kbrf_pkg::bundle_xfer_t push,
	output logic                   full,
	output kbrf_pkg::bundle_xfer_t head,
	input  logic                   pop
);
	import kbrf_pkg::*;

	bundle_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;
	assign head.valid = (cnt_q != '0);
	assign head.data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/kbrf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbrf_back: result serializer
// Walks the head bundle into the output register, one result per cycle when
// the output is not stalled, and flags the final result of each report.
// ----------------------------------------------------------------------------
module kbrf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kbrf_pkg::bundle_xfer_t head,
	output logic                   pop,
	kbrf_result_if.source          result
);
	import kbrf_pkg::*;

	cnt_t idx_q;
	logic out_valid_q;
	key_t key_q;
	logic status_q;
	logic last_q;
	logic load;
	logic is_last;

	assign load    = head.valid && (!out_valid_q || result.ready);
	assign is_last = (idx_q == head.data.count - cnt_t'(1));
	assign pop     = load && is_last;

	assign result.valid   = out_valid_q;
	assign result.key_out = key_q;
	assign result.status  = status_q;
	assign result.last    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + cnt_t'(1);
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q    <= head.data.err ? '0 : head.data.keys[idx_q];
			status_q <= head.data.err ? STATUS_LINK_ERR : STATUS_KEY;
			last_q   <= is_last;
		end
	end

endmodule
